@@ sv/drocc_pkg.sv @@
// ----------------------------------------------------------------------------
// drocc_pkg: shared types and constants
// Request and response words, the front-to-back queue entry, and the codes
// used by the depth region occlusion check.
// ----------------------------------------------------------------------------
package drocc_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_EOF   = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  localparam logic RESP_ADD   = 1'b0;
  localparam logic RESP_QUERY = 1'b1;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [15:0] FAR_MASK     = 16'hFFFC;
  localparam logic [3:0]  SLOT_NONE    = 4'hF;
  localparam logic [9:0]  RESET_WIDTH  = 10'd320;
  localparam logic [9:0]  RESET_HEIGHT = 10'd240;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [5:0]         radius;
    logic [15:0]        depth;
    logic [3:0]         check_index;
  } in_word_t;

  typedef struct packed {
    logic              resp_kind;
    logic signed [3:0] slot;
    logic              visible_flag;
  } out_word_t;

  // Classified request as it waits between front and back.
  typedef struct packed {
    req_t               kind;
    logic               offscreen;
    logic [9:0]         left;
    logic [9:0]         top;
    logic [6:0]         wid;
    logic [6:0]         hgt;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic               far;
    logic [3:0]         qidx;
  } entry_t;

endpackage

@@ sv/drocc_front.sv @@
// ----------------------------------------------------------------------------
// drocc_front: request classification
// Decodes a request, clips an add square against the screen and flags far
// depth samples, producing one queue entry.
// ----------------------------------------------------------------------------
module drocc_front
  import drocc_pkg::*;
(
  input  in_word_t   in_word,
  input  logic [9:0] screen_width,
  input  logic [9:0] screen_height,
  output entry_t     entry
);

  logic signed [12:0] x1, x2, y1, y2, sw, sh;
  logic signed [12:0] cl, ct, cr, cb;
  logic signed [12:0] ext_w, ext_h;

  always_comb begin
    sw = $signed({3'b000, screen_width});
    sh = $signed({3'b000, screen_height});
    x1 = $signed({in_word.pos_x[11], in_word.pos_x}) - $signed({7'b0, in_word.radius});
    x2 = $signed({in_word.pos_x[11], in_word.pos_x}) + $signed({7'b0, in_word.radius});
    y1 = $signed({in_word.pos_y[11], in_word.pos_y}) - $signed({7'b0, in_word.radius});
    y2 = $signed({in_word.pos_y[11], in_word.pos_y}) + $signed({7'b0, in_word.radius});

    cl = (x1 < 0) ? 13'sd0 : x1;
    ct = (y1 < 0) ? 13'sd0 : y1;
    cr = (x2 >= sw) ? sw - 13'sd1 : x2;
    cb = (y2 >= sh) ? sh - 13'sd1 : y2;
    ext_w = cr - cl + 13'sd1;
    ext_h = cb - ct + 13'sd1;

    entry.kind      = req_t'(in_word.req_type);
    entry.offscreen = (x2 < 0) || (y2 < 0) || (x1 >= sw) || (y1 >= sh);
    entry.left      = cl[9:0];
    entry.top       = ct[9:0];
    entry.wid       = ext_w[6:0];
    entry.hgt       = ext_h[6:0];
    entry.px        = in_word.pos_x;
    entry.py        = in_word.pos_y;
    entry.far       = (in_word.depth & FAR_MASK) == FAR_MASK;
    entry.qidx      = in_word.check_index;
  end

endmodule

@@ sv/drocc_queue.sv @@
// ----------------------------------------------------------------------------
// drocc_queue: two-entry queue
// Decouples the classifying front from the slot table so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module drocc_queue
  import drocc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   not_full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t     store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ sv/drocc_back.sv @@
// ----------------------------------------------------------------------------
// drocc_back: slot table and response register
// Holds the pending rectangles, marks them from far depth samples, commits
// flags at end of frame and answers add and query requests.
// ----------------------------------------------------------------------------
module drocc_back
  import drocc_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  entry_t    q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [CW-1:0]        active_count;
  logic [9:0]           rect_left   [NUM_SLOTS];
  logic [9:0]           rect_top    [NUM_SLOTS];
  logic [6:0]           rect_width  [NUM_SLOTS];
  logic [6:0]           rect_height [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] far_seen;
  logic [NUM_SLOTS-1:0] committed_flag;

  logic                 answers;
  logic                 full;
  logic                 add_ok;
  logic [NUM_SLOTS-1:0] hit;
  logic [NUM_SLOTS-1:0] commit_val;
  logic                 q_in_range;
  logic signed [12:0]   sx, sy;
  logic                 out_valid_next;

  always_comb begin
    answers    = (q_head.kind == REQ_ADD) || (q_head.kind == REQ_QUERY);
    q_pop      = q_valid && (!answers || !out_valid || out_ready);
    full       = (active_count >= CW'(NUM_SLOTS));
    add_ok     = !full && !q_head.offscreen;
    q_in_range = ({1'b0, q_head.qidx} < 5'(NUM_SLOTS));
    sx         = $signed({q_head.px[11], q_head.px});
    sy         = $signed({q_head.py[11], q_head.py});
  end

  // The answer register empties when taken and refills from an add or query.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (q_pop && answers) begin
      out_valid_next = 1'b1;
    end
  end

  // One compare lane per slot; all lanes look at the same sample.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i] = (CW'(i) < active_count) &&
               (sx >= $signed({3'b000, rect_left[i]})) &&
               (sx <  $signed({3'b000, rect_left[i]} + {6'b0, rect_width[i]})) &&
               (sy >= $signed({3'b000, rect_top[i]})) &&
               (sy <  $signed({3'b000, rect_top[i]} + {6'b0, rect_height[i]}));
      commit_val[i] = (CW'(i) < active_count) ? ~far_seen[i] : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count   <= '0;
      far_seen       <= '0;
      committed_flag <= '0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (q_pop) begin
        unique case (q_head.kind)
          REQ_ADD: begin
            if (add_ok) begin
              active_count <= active_count + CW'(1);
              far_seen[active_count[IW-1:0]] <= 1'b0;
            end
          end
          REQ_PIXEL: begin
            if (q_head.far) begin
              far_seen <= far_seen | hit;
            end
          end
          REQ_EOF: begin
            committed_flag <= commit_val;
            far_seen       <= '0;
            active_count   <= '0;
          end
          REQ_QUERY: ;
        endcase
      end
    end
  end

  // Rectangle storage and the response payload carry no reset.
  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == REQ_ADD && add_ok) begin
      rect_left[active_count[IW-1:0]]   <= q_head.left;
      rect_top[active_count[IW-1:0]]    <= q_head.top;
      rect_width[active_count[IW-1:0]]  <= q_head.wid;
      rect_height[active_count[IW-1:0]] <= q_head.hgt;
    end
    if (q_pop && q_head.kind == REQ_ADD) begin
      out_word.resp_kind    <= RESP_ADD;
      out_word.slot         <= add_ok ? $signed(4'(active_count)) : $signed(SLOT_NONE);
      out_word.visible_flag <= 1'b0;
    end else if (q_pop && q_head.kind == REQ_QUERY) begin
      out_word.resp_kind    <= RESP_QUERY;
      out_word.slot         <= 4'sd0;
      out_word.visible_flag <= q_in_range ? committed_flag[q_head.qidx[IW-1:0]] : 1'b1;
    end
  end

endmodule

@@ sv/depth_region_occlusion_check.sv @@
// ----------------------------------------------------------------------------
// depth_region_occlusion_check: occlusion query table over a depth stream
// Top level: configuration registers, classifying front, queue and slot
// table back end.
// ----------------------------------------------------------------------------
// Usage. Request words enter on in_valid/in_ready/in_word. An add word
// places a clipped square in the next free slot and answers with the slot
// number, or -1 when the square is off screen or the table is full. Depth
// pixel words, streamed in raster order, mark every pending slot whose
// rectangle covers a far sample. An end-of-frame word commits one flag per
// slot and empties the table; neither of these answers. A query word answers
// with the committed flag of one slot (1 for an index beyond the table).
// Answers leave on out_valid/out_ready/out_word in request order.
// An accepted word lands in the two-entry queue; the back end pops it from
// the queue head and registers any answer with out_valid. Throughput is one
// word per clock in either direction while the receiver does not stall; all
// slots are compared at once. When the receiver stalls, the answer waits in
// the output register; pixel and end-of-frame words behind it drain until an
// add or query reaches the queue head, and input stalls once the queue fills.
// The screen size registers (index 0 width, index 1 height) reset to 320 by
// 240. The user must write them through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce it. Reset empties the table and
// clears every committed flag.
// ----------------------------------------------------------------------------
module depth_region_occlusion_check
  import drocc_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [9:0] cfg_data
);

  logic [9:0] screen_width;
  logic [9:0] screen_height;
  entry_t     front_entry;
  entry_t     q_head;
  logic       q_not_empty;
  logic       q_pop;

  // Screen size registers; the index is a single bit so every write lands.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
      endcase
    end
  end

  // The front clips add squares with the current screen size before queuing.
  drocc_front u_front (
    .in_word       (in_word),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .entry         (front_entry)
  );

  drocc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && in_ready),
    .push_entry (front_entry),
    .not_full   (in_ready),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  drocc_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ test/depth_region_occlusion_check_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_region_occlusion_check_tb: self-checking bench for the occlusion table
// Drives request words through the valid/ready input and predicts every
// answer with an in-bench model of the slot table. Answers are checked field
// by field in order. A short directed run covers clipping, a full table, far
// pixels, commit, out-of-range queries and degenerate screen sizes. Random
// frames follow, under changing screen sizes, bursty input and a stalling
// receiver.
// ----------------------------------------------------------------------------
module depth_region_occlusion_check_tb;
  import drocc_pkg::*;

  localparam int NUM_SLOTS      = 8;
  localparam int RANDOM_WORDS   = 1400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      cfg_we;
  logic      cfg_index;
  logic [9:0] cfg_data;

  depth_region_occlusion_check #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Occlusion table model. It mirrors the block's state: the screen size, the
  // pending rectangles, their far-pixel marks and the committed flags.
  // --------------------------------------------------------------------------
  logic [9:0]  scr_w;
  logic [9:0]  scr_h;
  int          pend_count;
  logic [9:0]  reg_left [NUM_SLOTS];
  logic [9:0]  reg_top  [NUM_SLOTS];
  logic [6:0]  reg_wid  [NUM_SLOTS];
  logic [6:0]  reg_hgt  [NUM_SLOTS];
  logic        far_mark [NUM_SLOTS];
  logic        commit_flag [NUM_SLOTS];

  // Answers that the table owes, oldest first.
  out_word_t   pending_answers[$];

  int          fail_count  = 0;
  int          words_sent  = 0;
  int          burst_left  = 0;
  int          quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [3:0] got,
                                 input logic [3:0] want);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic void reset_table_model();
    scr_w      = RESET_WIDTH;
    scr_h      = RESET_HEIGHT;
    pend_count = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      far_mark[i]    = 1'b0;
      commit_flag[i] = 1'b0;
    end
  endfunction

  // Applies one accepted request word to the model and queues any answer it owes.
  function automatic void model_request(input in_word_t w);
    int        x;
    int        y;
    int        r;
    int        x1;
    int        y1;
    int        x2;
    int        y2;
    out_word_t ans;
    x   = $signed(w.pos_x);
    y   = $signed(w.pos_y);
    r   = int'(w.radius);
    ans = '0;
    case (w.req_type)
      REQ_ADD: begin
        x1 = x - r;
        y1 = y - r;
        x2 = x + r;
        y2 = y + r;
        ans.resp_kind = RESP_ADD;
        ans.slot      = SLOT_NONE;
        // A full table and a square wholly off screen both answer -1.
        if (pend_count < NUM_SLOTS &&
            !(x2 < 0 || y2 < 0 || x1 >= int'(scr_w) || y1 >= int'(scr_h))) begin
          if (x1 < 0) x1 = 0;
          if (y1 < 0) y1 = 0;
          if (x2 >= int'(scr_w)) x2 = int'(scr_w) - 1;
          if (y2 >= int'(scr_h)) y2 = int'(scr_h) - 1;
          // With a zero screen size the extent comes out as zero and the slot
          // covers no pixel at all.
          reg_left[pend_count] = 10'(x1);
          reg_top[pend_count]  = 10'(y1);
          reg_wid[pend_count]  = 7'(x2 - x1 + 1);
          reg_hgt[pend_count]  = 7'(y2 - y1 + 1);
          far_mark[pend_count] = 1'b0;
          ans.slot = 4'(pend_count);
          pend_count++;
        end
        pending_answers.push_back(ans);
      end
      REQ_PIXEL: begin
        if ((w.depth & FAR_MASK) == FAR_MASK) begin
          for (int i = 0; i < pend_count; i++) begin
            if (x >= int'(reg_left[i]) && x < int'(reg_left[i]) + int'(reg_wid[i]) &&
                y >= int'(reg_top[i]) && y < int'(reg_top[i]) + int'(reg_hgt[i])) begin
              far_mark[i] = 1'b1;
            end
          end
        end
      end
      REQ_EOF: begin
        // Pending slots commit visible unless a far pixel hit them; unused
        // slots always commit visible.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          commit_flag[i] = (i < pend_count) ? ~far_mark[i] : 1'b1;
          far_mark[i]    = 1'b0;
        end
        pend_count = 0;
      end
      default: begin
        ans.resp_kind    = RESP_QUERY;
        ans.visible_flag = 1'b1;
        if (int'(w.check_index) < NUM_SLOTS) begin
          ans.visible_flag = commit_flag[w.check_index];
        end
        pending_answers.push_back(ans);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers. Inputs move on the falling edge; acceptance is seen on
  // the rising edge.
  // --------------------------------------------------------------------------
  function automatic in_word_t make_word(input req_t kind, input int x, input int y,
                                         input int r, input int d, input int q);
    in_word_t w;
    w.req_type    = kind;
    w.pos_x       = 12'(x);
    w.pos_y       = 12'(y);
    w.radius      = 6'(r);
    w.depth       = 16'(d);
    w.check_index = 4'(q);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w.req_type    = 2'($urandom);
    w.pos_x       = 12'($urandom);
    w.pos_y       = 12'($urandom);
    w.radius      = 6'($urandom);
    w.depth       = 16'($urandom);
    w.check_index = 4'($urandom);
    return w;
  endfunction

  // Sends one word. The sender runs in bursts; between bursts valid drops for
  // a random gap, and some bursts follow with no gap at all. Valid is left
  // high on return so that a following word keeps it up without a glitch.
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_request(w);
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the input off until every owed answer has come out, then lets the
  // pipeline settle, since pixel and end-of-frame words leave no answer.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_screen(input logic idx, input logic [9:0] val);
    drain_answers();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) begin
      scr_w = val;
    end else begin
      scr_h = val;
    end
  endtask

  function automatic logic [9:0] pick_screen_size();
    case ($urandom_range(0, 6))
      0:       return 10'd1;
      1:       return 10'd1023;
      2:       return 10'd0;
      3:       return 10'($urandom_range(1, 1023));
      default: return 10'($urandom_range(1, 64));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // After reset every committed flag reads 0; an index past the table reads 1.
  task automatic test_reset_state();
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 15));
  endtask

  // Squares off each edge of the default 320 by 240 screen are rejected;
  // squares over the corners are clipped.
  task automatic test_add_clipping();
    send_word(make_word(REQ_ADD, -2048, -2048, 63, 0, 0));
    send_word(make_word(REQ_ADD, 100, -1, 0, 0, 0));
    send_word(make_word(REQ_ADD, 320, 10, 0, 0, 0));
    send_word(make_word(REQ_ADD, 2047, 2047, 0, 0, 0));
    send_word(make_word(REQ_ADD, 0, 0, 63, 0, 0));
    send_word(make_word(REQ_ADD, 319, 239, 63, 0, 0));
    send_word(make_word(REQ_ADD, 100, 100, 0, 0, 0));
  endtask

  // Far and near depth words, pixels off the screen, then a full table and
  // the commit that empties it.
  task automatic test_pixels_and_commit();
    send_word(make_word(REQ_PIXEL, 100, 100, 0, 16'hFFFC, 0));
    send_word(make_word(REQ_PIXEL, 0, 0, 0, 16'hFFFB, 0));
    send_word(make_word(REQ_PIXEL, 10, 10, 0, 16'h0000, 0));
    send_word(make_word(REQ_PIXEL, -2048, 2047, 63, 16'hFFFF, 15));
    for (int i = 0; i < 5; i++) begin
      send_word(make_word(REQ_ADD, 150 + 4 * i, 120, 1, 0, 0));
    end
    // The table now holds eight squares, so this one cannot be placed.
    send_word(make_word(REQ_ADD, 160, 120, 5, 0, 0));
    send_word(make_word(REQ_EOF, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 2));
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 7));
  endtask

  // A zero screen leaves an empty rectangle that commits visible. A stored
  // rectangle keeps its place when the screen grows afterwards.
  task automatic test_screen_extremes();
    write_screen(CFG_SCREEN_WIDTH, 10'd0);
    write_screen(CFG_SCREEN_HEIGHT, 10'd0);
    send_word(make_word(REQ_ADD, 0, 0, 1, 0, 0));
    send_word(make_word(REQ_ADD, 5, 5, 0, 0, 0));
    write_screen(CFG_SCREEN_WIDTH, 10'd1023);
    write_screen(CFG_SCREEN_HEIGHT, 10'd1023);
    send_word(make_word(REQ_PIXEL, 0, 0, 0, 16'hFFFF, 0));
    send_word(make_word(REQ_ADD, 1000, 1000, 63, 0, 0));
    send_word(make_word(REQ_PIXEL, 1022, 1022, 0, 16'hFFFD, 0));
    send_word(make_word(REQ_EOF, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 0));
    send_word(make_word(REQ_QUERY, 0, 0, 0, 0, 1));
  endtask

  // --------------------------------------------------------------------------
  // Random frames: adds, then pixels spread over the screen or aimed near the
  // last square, then usually an end of frame and a few queries. Stray words of
  // any kind are mixed in now and then.
  // --------------------------------------------------------------------------
  task automatic maybe_stray_word();
    if ($urandom_range(0, 11) == 0) begin
      send_word(random_word());
    end
  endtask

  task automatic run_random_frame();
    in_word_t w;
    int       cx;
    int       cy;
    cx = $urandom_range(0, scr_w);
    cy = $urandom_range(0, scr_h);
    repeat ($urandom_range(0, 10)) begin
      maybe_stray_word();
      w = random_word();
      w.req_type = REQ_ADD;
      if ($urandom_range(0, 7) != 0) begin
        cx = $urandom_range(0, int'(scr_w) + 140) - 70;
        cy = $urandom_range(0, int'(scr_h) + 140) - 70;
        w.pos_x = 12'(cx);
        w.pos_y = 12'(cy);
      end
      send_word(w);
    end
    repeat ($urandom_range(0, 30)) begin
      maybe_stray_word();
      w = random_word();
      w.req_type = REQ_PIXEL;
      case ($urandom_range(0, 9))
        0: ;
        1, 2, 3, 4: begin
          w.pos_x = 12'(cx + $urandom_range(0, 140) - 70);
          w.pos_y = 12'(cy + $urandom_range(0, 140) - 70);
        end
        default: begin
          w.pos_x = 12'($urandom_range(0, int'(scr_w) + 10) - 5);
          w.pos_y = 12'($urandom_range(0, int'(scr_h) + 10) - 5);
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        w.depth = FAR_MASK | 16'($urandom_range(0, 3));
      end
      send_word(w);
    end
    if ($urandom_range(0, 3) != 0) begin
      w = random_word();
      w.req_type = REQ_EOF;
      send_word(w);
    end
    repeat ($urandom_range(0, 4)) begin
      w = random_word();
      w.req_type = REQ_QUERY;
      send_word(w);
    end
  endtask

  task automatic test_random_traffic();
    int start_count;
    int frame_no;
    start_count = words_sent;
    frame_no    = 0;
    while (words_sent - start_count < RANDOM_WORDS) begin
      if (frame_no % 6 == 0) begin
        write_screen(CFG_SCREEN_WIDTH, pick_screen_size());
        write_screen(CFG_SCREEN_HEIGHT, pick_screen_size());
      end else if ($urandom_range(0, 9) == 0) begin
        // Let the block run completely dry before the next frame.
        drain_answers();
      end
      run_random_frame();
      frame_no++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: the ready pattern steps in turn between always ready, coin flips,
  // occasional long stalls and mostly stalled.
  // --------------------------------------------------------------------------
  int ready_cycle = 0;
  int stall_left  = 0;

  always @(negedge clk) begin
    ready_cycle++;
    case ((ready_cycle / 300) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 12);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Each answer word taken by the receiver is compared with the oldest owed
  // answer.
  always @(posedge clk) begin : answer_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with none owed", {3'b000, out_word.resp_kind}, 4'h0);
      end else begin
        want = pending_answers.pop_front();
        if (out_word.resp_kind !== want.resp_kind) begin
          report_mismatch("resp_kind", {3'b000, out_word.resp_kind},
                          {3'b000, want.resp_kind});
        end
        if (out_word.slot !== want.slot) begin
          report_mismatch("slot", out_word.slot, want.slot);
        end
        if (out_word.visible_flag !== want.visible_flag) begin
          report_mismatch("visible_flag", {3'b000, out_word.visible_flag},
                          {3'b000, want.visible_flag});
        end
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either side is a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[depth_region_occlusion_check] ERROR");
      $finish;
    end
  end

  initial begin
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SCREEN_WIDTH;
    cfg_data  = '0;
    rst       = 1'b1;
    reset_table_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_add_clipping();
    test_pixels_and_commit();
    test_screen_extremes();
    test_random_traffic();

    drain_answers();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[depth_region_occlusion_check] OK");
    end else begin
      $display("[depth_region_occlusion_check] ERROR");
    end
    $finish;
  end

endmodule
